FILE: src/framed_position_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef FRAMED_POSITION_RECEIVER_DEFINES_SVH
`define FRAMED_POSITION_RECEIVER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpr assertion failed");

// Consequent checked in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpr assertion failed");

`endif

FILE: src/fpr_pkg.sv
// Package for the framed position receiver.
// Frame constants and the frame record type; no dependencies.
`default_nettype none

package fpr_pkg;

    localparam int PAYLOAD_BYTES = 10;

    localparam logic [7:0] START_BYTE_RESET = 8'd13;

    localparam logic [3:0] PHASE_HUNT = 4'd0;
    localparam logic [3:0] PHASE_LAST = 4'd10;

    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] x_position;
        logic [15:0] y_position;
        logic [15:0] x_reference;
        logic [15:0] y_reference;
        logic [15:0] checksum;
        logic [15:0] bytes_taken;
    } frame_rec_t;

endpackage

`default_nettype wire

FILE: src/fpr_front.sv
// Front end: start byte hunt, byte tally and frame assembly.
// Uses fpr_pkg and the assertion macros header.
`default_nettype none
`include "framed_position_receiver_defines.svh"

module fpr_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          rx_byte,
    output logic                     rec_push,
    output fpr_pkg::frame_rec_t      rec_data,
    input  wire logic                rec_full
);
    import fpr_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [15:0] tally_reg, tally_next, tally_inc;
    logic [7:0]  bytes_reg [PAYLOAD_BYTES-1];
    logic        accept;
    logic        hunting;
    logic        closing;
    logic [3:0]  wr_idx;

    assign cfg_ready = 1'b1;
    assign hunting   = (phase_reg == PHASE_HUNT) || (phase_reg > PHASE_LAST);
    assign closing   = (phase_reg == PHASE_LAST);
    assign full      = closing && rec_full;
    assign accept    = push && !full;
    assign wr_idx    = phase_reg - 4'd1;
    assign tally_inc = (tally_reg == TALLY_MAX) ? tally_reg : tally_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        tally_next = tally_reg;
        if (accept)
        begin
            tally_next = tally_inc;
            if (hunting)
            begin
                phase_next = (rx_byte == start_byte_reg) ? 4'd1 : PHASE_HUNT;
            end
            else if (closing)
            begin
                phase_next = PHASE_HUNT;
                tally_next = '0;
            end
            else
            begin
                phase_next = phase_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            phase_reg      <= PHASE_HUNT;
            tally_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_byte_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            tally_reg <= tally_next;
        end
    end

    // Hold payload bytes; the closing byte goes straight into the record.
    always_ff @(posedge clk)
    begin
        if (accept && !hunting && !closing)
        begin
            bytes_reg[wr_idx] <= rx_byte;
        end
    end

    assign rec_push               = accept && closing;
    assign rec_data.x_position    = {bytes_reg[0], bytes_reg[1]};
    assign rec_data.y_position    = {bytes_reg[2], bytes_reg[3]};
    assign rec_data.x_reference   = {bytes_reg[4], bytes_reg[5]};
    assign rec_data.y_reference   = {bytes_reg[6], bytes_reg[7]};
    assign rec_data.checksum      = {bytes_reg[8], rx_byte};
    assign rec_data.bytes_taken   = tally_inc;

    `FPR_ASSERT_NEXT(a_emit_returns_to_hunt, rec_push, phase_reg == PHASE_HUNT && tally_reg == 16'd0)
    `FPR_ASSERT_SAME(a_phase_in_range, 1'b1, phase_reg <= PHASE_LAST)

endmodule

`default_nettype wire

FILE: src/fpr_queue.sv
// Short frame record queue between the front and back ends.
// Uses fpr_pkg and the assertion macros header.
`default_nettype none
`include "framed_position_receiver_defines.svh"

module fpr_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire fpr_pkg::frame_rec_t wr_data,
    output logic                     q_full,
    input  wire logic                rd_en,
    output fpr_pkg::frame_rec_t      rd_data,
    output logic                     q_empty
);
    import fpr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        ptr_adv = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_adv(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_adv(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `FPR_ASSERT_SAME(a_no_overflow, wr_en, !q_full)
    `FPR_ASSERT_SAME(a_no_underflow, rd_en, !q_empty)

endmodule

`default_nettype wire

FILE: src/fpr_back.sv
// Back end: checksum and position check, result register.
// Uses fpr_pkg.
`default_nettype none

module fpr_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fpr_pkg::frame_rec_t rec_data,
    input  wire logic                rec_empty,
    output logic                     rec_pop,
    input  wire logic                pop,
    output logic                     empty,
    output logic [15:0]              x_position,
    output logic [15:0]              y_position,
    output logic [15:0]              x_reference,
    output logic [15:0]              y_reference,
    output logic                     frame_ok,
    output logic [15:0]              bytes_taken
);
    import fpr_pkg::*;

    logic        out_valid_reg;
    logic [15:0] x_pos_reg, y_pos_reg, x_ref_reg, y_ref_reg, taken_reg;
    logic        ok_reg;
    logic [15:0] sum;
    logic        ok_next;

    assign sum     = ~(rec_data.x_position + rec_data.y_position
                     + rec_data.x_reference + rec_data.y_reference);
    assign ok_next = (sum == rec_data.checksum) && (rec_data.x_position != '0)
                     && (rec_data.y_position != '0);
    assign rec_pop = !rec_empty && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            x_pos_reg <= rec_data.x_position;
            y_pos_reg <= rec_data.y_position;
            x_ref_reg <= rec_data.x_reference;
            y_ref_reg <= rec_data.y_reference;
            taken_reg <= rec_data.bytes_taken;
            ok_reg    <= ok_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign x_position  = x_pos_reg;
    assign y_position  = y_pos_reg;
    assign x_reference = x_ref_reg;
    assign y_reference = y_ref_reg;
    assign frame_ok    = ok_reg;
    assign bytes_taken = taken_reg;

endmodule

`default_nettype wire

FILE: src/framed_position_receiver.sv
// Framed position receiver: takes one received byte per cycle while full is low, hunts
// for the start byte (cfg_data write, 13 after reset), then gathers ten bytes into x/y
// position, x/y reference and checksum and produces one result per frame. The byte input
// sustains one transfer every cycle; full rises only on a frame's closing byte while the
// frame queue holds QUEUE_DEPTH frames that the result side has not taken. A result passes
// through the frame queue and then the result register, which captures the checksum and
// position check; while the result side does not pop, it waits there.
// Uses fpr_pkg, fpr_front, fpr_queue and fpr_back.
`default_nettype none

module framed_position_receiver
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [15:0]      x_position,
    output logic [15:0]      y_position,
    output logic [15:0]      x_reference,
    output logic [15:0]      y_reference,
    output logic             frame_ok,
    output logic [15:0]      bytes_taken
);
    import fpr_pkg::*;

    frame_rec_t wr_rec, rd_rec;
    logic       rec_push, rec_full, rec_pop, rec_empty;

    fpr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .rec_push  (rec_push),
        .rec_data  (wr_rec),
        .rec_full  (rec_full)
    );

    fpr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (wr_rec),
        .q_full  (rec_full),
        .rd_en   (rec_pop),
        .rd_data (rd_rec),
        .q_empty (rec_empty)
    );

    fpr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_data    (rd_rec),
        .rec_empty   (rec_empty),
        .rec_pop     (rec_pop),
        .pop         (pop),
        .empty       (empty),
        .x_position  (x_position),
        .y_position  (y_position),
        .x_reference (x_reference),
        .y_reference (y_reference),
        .frame_ok    (frame_ok),
        .bytes_taken (bytes_taken)
    );

endmodule

`default_nettype wire

FILE: verif/fpr_tb_pkg.sv
`timescale 1ns / 100ps
// Frame ledger for the framed position receiver testbench: tracks the hunt and
// payload phase byte by byte and holds the frames the block still owes.
// Depends on fpr_pkg for the reset start byte, phase codes and tally limit.

package fpr_tb_pkg;

    import fpr_pkg::*;

    typedef struct packed {
        logic [15:0] x_position;
        logic [15:0] y_position;
        logic [15:0] x_reference;
        logic [15:0] y_reference;
        logic        frame_ok;
        logic [15:0] bytes_taken;
    } frame_result_t;

    class frame_ledger;

        logic [7:0]    start_byte;
        logic [3:0]    phase;
        logic [7:0]    held_bytes [PAYLOAD_BYTES];
        logic [15:0]   tally;
        frame_result_t frames_due [$];
        int            fail_count;

        function new();
            start_byte = START_BYTE_RESET;
            phase      = PHASE_HUNT;
            tally      = 16'd0;
            fail_count = 0;
            foreach (held_bytes[i])
                held_bytes[i] = 8'h00;
        endfunction

        function void set_start_byte(input logic [7:0] value);
            start_byte = value;
        endfunction

        function void take_byte(input logic [7:0] b);
            frame_result_t frame;
            logic [15:0]   sum;
            logic [15:0]   checksum;
            if (tally != TALLY_MAX)
                tally = tally + 16'd1;
            if (phase == PHASE_HUNT || phase > PHASE_LAST)
            begin
                phase = (b == start_byte) ? PHASE_HUNT + 4'd1 : PHASE_HUNT;
                return;
            end
            held_bytes[phase - 4'd1] = b;
            if (phase < PHASE_LAST)
            begin
                phase = phase + 4'd1;
                return;
            end
            frame.x_position  = {held_bytes[0], held_bytes[1]};
            frame.y_position  = {held_bytes[2], held_bytes[3]};
            frame.x_reference = {held_bytes[4], held_bytes[5]};
            frame.y_reference = {held_bytes[6], held_bytes[7]};
            checksum          = {held_bytes[8], held_bytes[9]};
            sum = frame.x_position + frame.y_position + frame.x_reference + frame.y_reference;
            frame.frame_ok    = (~sum == checksum) && (frame.x_position != 16'd0)
                                && (frame.y_position != 16'd0);
            frame.bytes_taken = tally;
            frames_due.push_back(frame);
            phase = PHASE_HUNT;
            tally = 16'd0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $time, msg);
            fail_count++;
        endtask

        task match_frame(input frame_result_t got);
            frame_result_t want;
            if (frames_due.size() == 0)
            begin
                report($sformatf("frame with none due: x_position %h bytes_taken %0d",
                                 got.x_position, got.bytes_taken));
                return;
            end
            want = frames_due.pop_front();
            if (got.x_position !== want.x_position)
                report($sformatf("x_position %h, expected %h", got.x_position, want.x_position));
            if (got.y_position !== want.y_position)
                report($sformatf("y_position %h, expected %h", got.y_position, want.y_position));
            if (got.x_reference !== want.x_reference)
                report($sformatf("x_reference %h, expected %h",
                                 got.x_reference, want.x_reference));
            if (got.y_reference !== want.y_reference)
                report($sformatf("y_reference %h, expected %h",
                                 got.y_reference, want.y_reference));
            if (got.frame_ok !== want.frame_ok)
                report($sformatf("frame_ok %b, expected %b", got.frame_ok, want.frame_ok));
            if (got.bytes_taken !== want.bytes_taken)
                report($sformatf("bytes_taken %0d, expected %0d",
                                 got.bytes_taken, want.bytes_taken));
        endtask

    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the framed position receiver testbench: clock, reset, byte and result
// queue drivers, start byte writes, directed and random frame traffic.
// Depends on fpr_pkg, fpr_tb_pkg and the framed_position_receiver RTL.

module tb_top;

    import fpr_pkg::*;
    import fpr_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NOISE_BYTES    = 40;
    localparam int LIMIT_NS       = 4_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'h00;
    logic        push      = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        pop       = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic [15:0] x_reference;
    logic [15:0] y_reference;
    logic        frame_ok;
    logic [15:0] bytes_taken;

    frame_ledger ledger = new();
    int          sent_items = 0;
    logic [7:0]  start_now  = START_BYTE_RESET;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    framed_position_receiver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .pop         (pop),
        .empty       (empty),
        .x_position  (x_position),
        .y_position  (y_position),
        .x_reference (x_reference),
        .y_reference (y_reference),
        .frame_ok    (frame_ok),
        .bytes_taken (bytes_taken)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] good_sum(input logic [15:0] x, input logic [15:0] y,
                                             input logic [15:0] xr, input logic [15:0] yr);
        logic [15:0] s;
        s = x + y + xr + yr;
        return ~s;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        push    <= 1'b1;
        rx_byte <= b;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        ledger.take_byte(b);
        sent_items++;
    endtask

    task automatic hold_push(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic quiesce();
        @(negedge clk);
        push <= 1'b0;
        while (ledger.frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        ledger.set_start_byte(value);
        start_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_payload(input logic [79:0] p, input int first, input int last,
                                input bit gaps);
        for (int i = first; i <= last; i++)
        begin
            send_byte(p[79 - 8 * i -: 8]);
            if (gaps)
                hold_push(gap_len());
        end
    endtask

    task automatic send_frame(input logic [7:0] sof, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] xr,
                              input logic [15:0] yr, input logic [15:0] ck, input bit gaps);
        send_byte(sof);
        if (gaps)
            hold_push(gap_len());
        send_payload({x, y, xr, yr, ck}, 0, PAYLOAD_BYTES - 1, gaps);
    endtask

    task automatic random_traffic(input int count);
        int          stop;
        int          n;
        bit          gaps;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] xr;
        logic [15:0] yr;
        logic [15:0] ck;
        stop = sent_items + count;
        while (sent_items < stop)
        begin
            gaps = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 8)
            begin
                n = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
                repeat (n)
                begin
                    send_byte(8'($urandom));
                    if (gaps)
                        hold_push(gap_len());
                end
                x  = pick_word();
                y  = pick_word();
                xr = pick_word();
                yr = pick_word();
                ck = good_sum(x, y, xr, yr);
                case ($urandom_range(0, 9))
                    0, 1:    ck = ck ^ (16'h0001 << $urandom_range(0, 15));
                    2:       ck = 16'($urandom);
                    default: ;
                endcase
                send_frame(start_now, x, y, xr, yr, ck, gaps);
            end
            else
            begin
                n = $urandom_range(1, 15);
                repeat (n)
                begin
                    send_byte(8'($urandom));
                    if (gaps)
                        hold_push(gap_len());
                end
            end
        end
    endtask

    initial
    begin
        int  hold;
        bit  steady;
        hold   = 0;
        steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                steady = !steady;
            if (!steady && hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            ledger.match_frame(frame_result_t'{x_position, y_position, x_reference,
                                               y_reference, frame_ok, bytes_taken});
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [7:0]  noise;
        logic [79:0] split;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h5A);
        send_frame(START_BYTE_RESET, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000,
                   good_sum(16'hFFFF, 16'h0001, 16'h0000, 16'h8000), 1'b0);
        // start byte inside the payload, zero y position
        send_frame(START_BYTE_RESET, 16'h0D0D, 16'h0000, 16'hFFFF, 16'h0D0D,
                   good_sum(16'h0D0D, 16'h0000, 16'hFFFF, 16'h0D0D), 1'b0);

        // change the start byte with a frame half taken; the frame completes as before
        split = {16'h1234, 16'h00FF, 16'hFF00, 16'h7FFF,
                 good_sum(16'h1234, 16'h00FF, 16'hFF00, 16'h7FFF) ^ 16'h0100};
        send_byte(START_BYTE_RESET);
        send_payload(split, 0, 3, 1'b0);
        quiesce();
        write_start_byte(8'hFF);
        send_payload(split, 4, PAYLOAD_BYTES - 1, 1'b0);

        // count dropped bytes into the tally, then check it restarts
        quiesce();
        write_start_byte(8'hA5);
        repeat (NOISE_BYTES)
        begin
            noise = 8'($urandom);
            if (noise == 8'hA5)
                noise = 8'h5A;
            send_byte(noise);
        end
        send_frame(8'hA5, 16'h0102, 16'h0304, 16'h0506, 16'h0708,
                   good_sum(16'h0102, 16'h0304, 16'h0506, 16'h0708), 1'b0);
        send_frame(8'hA5, 16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A,
                   good_sum(16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A), 1'b0);

        quiesce();
        write_start_byte(8'hFF);
        random_traffic(PHASE_ITEMS);
        quiesce();
        write_start_byte(8'h00);
        random_traffic(PHASE_ITEMS);
        quiesce();
        write_start_byte(8'($urandom_range(1, 254)));
        random_traffic(PHASE_ITEMS);
        quiesce();
        write_start_byte(START_BYTE_RESET);
        random_traffic(PHASE_ITEMS);
        quiesce();

        if (ledger.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/fpr_pkg.sv
src/fpr_front.sv
src/fpr_queue.sv
src/fpr_back.sv
src/framed_position_receiver.sv
verif/fpr_tb_pkg.sv
verif/tb_top.sv
